[src/command_line_argument_splitter_core_macros.svh]
// assertion macros shared by the splitter rtl files
// expects i_clk and i_rst_n in the scope of every use
`ifndef COMMAND_LINE_ARGUMENT_SPLITTER_CORE_MACROS_SVH
`define COMMAND_LINE_ARGUMENT_SPLITTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CLAS_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("splitter invariant violated");
`define CLAS_ASSERT_IMPLY(lbl, cond, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("splitter implication violated");
`else
`define CLAS_ASSERT_ALWAYS(lbl, expr)
`define CLAS_ASSERT_IMPLY(lbl, cond, expr)
`endif
`endif

[src/clas_pkg.sv]
// shared types and constants for the command line argument splitter
// no dependencies
package clas_pkg;

    localparam int UnitW  = 16;
    localparam int RepW   = 8;
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int CntW   = QAw + 1;

    localparam logic [RepW-1:0]  MaxBackslashRun = 8'd255;
    localparam logic [UnitW-1:0] ChQuote  = 16'h0022;
    localparam logic [UnitW-1:0] ChBslash = 16'h005C;
    localparam logic [UnitW-1:0] ChSpace  = 16'h0020;
    localparam logic [UnitW-1:0] ChTab    = 16'h0009;
    localparam logic [1:0]       QuoteWrap = 2'd3;

    typedef struct packed {
        logic [UnitW-1:0] unit;
        logic             terminator;
    } t_in;

    typedef struct packed {
        logic [UnitW-1:0] out_unit;
        logic [RepW-1:0]  repeat_res;
        logic             arg_end;
        logic             line_end;
        logic             overflow;
    } t_res;

    // one queue entry: the results caused by one input transaction
    typedef struct packed {
        logic two;
        t_res first;
        t_res second;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qhead;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_QPATH = 3'd1,
        PH_UPATH = 3'd2,
        PH_GAP   = 3'd3,
        PH_ARG   = 3'd4
    } t_phase;

endpackage

[src/clas_front.sv]
// front end: accepts code units, tracks splitting state, builds result entries
// depends on clas_pkg
module clas_front import clas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    input  logic i_full,
    output logic o_stall,
    output logic o_push,
    output t_cmd o_cmd
);

    t_phase          r_phase, n_phase;
    logic [1:0]      r_qc, n_qc;
    logic [RepW-1:0] r_bs, n_bs;
    logic            r_iqr, n_iqr;
    logic            r_ovp, n_ovp;

    logic accept;
    logic have0, have1;
    t_res res0, res1;

    function automatic t_res mk_res(input logic [UnitW-1:0] u, input logic [RepW-1:0] rep,
                                    input logic ae, input logic le, input logic ov);
        t_res r;
        r.out_unit   = (rep != '0) ? u : '0;
        r.repeat_res = rep;
        r.arg_end    = ae;
        r.line_end   = le;
        r.overflow   = ov;
        return r;
    endfunction

    function automatic logic is_blank(input logic [UnitW-1:0] u);
        return (u == ChSpace) || (u == ChTab);
    endfunction

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        logic [UnitW-1:0] u;
        logic             arg_go;
        logic [1:0]       a_qc;
        logic [RepW-1:0]  a_bs;
        logic             a_iqr;
        logic             a_ovp;
        logic             ov;
        logic             done;
        logic [RepW-1:0]  half;

        u      = i_data.unit;
        arg_go = 1'b0;
        a_qc   = r_qc;
        a_bs   = r_bs;
        a_iqr  = r_iqr;
        a_ovp  = r_ovp;
        ov     = 1'b0;
        done   = 1'b0;
        half   = '0;

        n_phase = r_phase;
        n_qc    = r_qc;
        n_bs    = r_bs;
        n_iqr   = r_iqr;
        n_ovp   = r_ovp;
        have0   = 1'b0;
        have1   = 1'b0;
        res0    = '0;
        res1    = '0;

        if (i_data.terminator) begin
            have0 = 1'b1;
            unique case (r_phase)
                PH_START, PH_QPATH, PH_UPATH: res0 = mk_res('0, '0, 1'b1, 1'b1, 1'b0);
                PH_ARG:  res0 = mk_res(ChBslash, r_bs, 1'b1, 1'b1, r_ovp);
                default: res0 = mk_res('0, '0, 1'b0, 1'b1, 1'b0);
            endcase
            n_phase = PH_START;
            n_qc    = '0;
            n_bs    = '0;
            n_iqr   = 1'b0;
            n_ovp   = 1'b0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (u == ChQuote) begin
                        n_phase = PH_QPATH;
                    end else if (is_blank(u)) begin
                        have0   = 1'b1;
                        res0    = mk_res('0, '0, 1'b1, 1'b0, 1'b0);
                        n_phase = PH_GAP;
                    end else begin
                        have0   = 1'b1;
                        res0    = mk_res(u, RepW'(1), 1'b0, 1'b0, 1'b0);
                        n_phase = PH_UPATH;
                    end
                end
                PH_QPATH: begin
                    have0 = 1'b1;
                    if (u == ChQuote) begin
                        res0    = mk_res('0, '0, 1'b1, 1'b0, 1'b0);
                        n_phase = PH_GAP;
                    end else begin
                        res0 = mk_res(u, RepW'(1), 1'b0, 1'b0, 1'b0);
                    end
                end
                PH_UPATH: begin
                    have0 = 1'b1;
                    if (is_blank(u)) begin
                        res0    = mk_res('0, '0, 1'b1, 1'b0, 1'b0);
                        n_phase = PH_GAP;
                    end else begin
                        res0 = mk_res(u, RepW'(1), 1'b0, 1'b0, 1'b0);
                    end
                end
                PH_ARG: arg_go = 1'b1;
                default: begin
                    // gap between arguments: a non-blank opens a fresh argument
                    if (!is_blank(u)) begin
                        n_phase = PH_ARG;
                        arg_go  = 1'b1;
                        a_qc    = '0;
                        a_bs    = '0;
                        a_iqr   = 1'b0;
                        a_ovp   = 1'b0;
                    end else begin
                        n_phase = PH_GAP;
                    end
                end
            endcase

            if (arg_go) begin
                ov = a_ovp;
                if (a_iqr) begin
                    if (u == ChQuote) begin
                        a_qc = a_qc + 2'd1;
                        if (a_qc == QuoteWrap) begin
                            have0 = 1'b1;
                            res0  = mk_res(ChQuote, RepW'(1), 1'b0, 1'b0, 1'b0);
                            a_qc  = '0;
                        end
                        done = 1'b1;
                    end else begin
                        if (a_qc == 2'd2) begin
                            a_qc = '0;
                        end
                        a_iqr = 1'b0;
                    end
                end

                if (!done) begin
                    if (is_blank(u) && (a_qc == '0)) begin
                        have0   = 1'b1;
                        res0    = mk_res(ChBslash, a_bs, 1'b1, 1'b0, ov);
                        a_bs    = '0;
                        a_ovp   = 1'b0;
                        n_phase = PH_GAP;
                    end else if (u == ChBslash) begin
                        if (a_bs < MaxBackslashRun) begin
                            a_bs = a_bs + RepW'(1);
                        end else begin
                            a_ovp = 1'b1;
                        end
                    end else if (u == ChQuote) begin
                        half = a_bs >> 1;
                        if (half != '0) begin
                            have0 = 1'b1;
                            res0  = mk_res(ChBslash, half, 1'b0, 1'b0, ov);
                        end
                        if (!a_bs[0]) begin
                            a_qc = a_qc + 2'd1;
                        end else if (have0) begin
                            have1 = 1'b1;
                            res1  = mk_res(ChQuote, RepW'(1), 1'b0, 1'b0, 1'b0);
                        end else begin
                            have0 = 1'b1;
                            res0  = mk_res(ChQuote, RepW'(1), 1'b0, 1'b0, ov);
                        end
                        a_bs  = '0;
                        a_ovp = 1'b0;
                        a_iqr = 1'b1;
                    end else begin
                        if (a_bs != '0) begin
                            have0 = 1'b1;
                            have1 = 1'b1;
                            res0  = mk_res(ChBslash, a_bs, 1'b0, 1'b0, ov);
                            res1  = mk_res(u, RepW'(1), 1'b0, 1'b0, 1'b0);
                        end else begin
                            have0 = 1'b1;
                            res0  = mk_res(u, RepW'(1), 1'b0, 1'b0, ov);
                        end
                        a_bs  = '0;
                        a_ovp = 1'b0;
                    end
                end

                n_qc  = a_qc;
                n_bs  = a_bs;
                n_iqr = a_iqr;
                n_ovp = a_ovp;
            end
        end
    end

    assign o_push       = accept && have0;
    assign o_cmd.two    = have1;
    assign o_cmd.first  = res0;
    assign o_cmd.second = res1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_qc    <= '0;
            r_bs    <= '0;
            r_iqr   <= 1'b0;
            r_ovp   <= 1'b0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_qc    <= n_qc;
            r_bs    <= n_bs;
            r_iqr   <= n_iqr;
            r_ovp   <= n_ovp;
        end
    end

endmodule

[src/clas_queue.sv]
// small fifo of result entries between front and back ends
// depends on clas_pkg and the assertion macro header
`include "command_line_argument_splitter_core_macros.svh"
module clas_queue import clas_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_cmd   i_cmd,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_cmd            r_mem [QDepth];
    logic [QAw-1:0]  r_wr, r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full       = (r_cnt == CntW'(QDepth));
    assign o_head.valid = (r_cnt != '0);
    assign o_head.cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAw'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAw'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CntW'(1);
                2'b01:   r_cnt <= r_cnt - CntW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `CLAS_ASSERT_ALWAYS(a_cnt_range, r_cnt <= CntW'(QDepth))
    `CLAS_ASSERT_ALWAYS(a_ptr_track, QAw'(r_wr - r_rd) == r_cnt[QAw-1:0])
    `CLAS_ASSERT_IMPLY(a_no_overrun, i_push, !o_full)
    `CLAS_ASSERT_IMPLY(a_no_underrun, i_pop, r_cnt != '0)

endmodule

[src/clas_back.sv]
// back end: unpacks queue entries into single results behind an output register
// depends on clas_pkg and the assertion macro header
`include "command_line_argument_splitter_core_macros.svh"
module clas_back import clas_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qhead i_head,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_stall,
    output t_res   o_data
);

    logic r_valid, n_valid;
    logic r_pend, n_pend;
    t_res r_res, n_res;
    t_res r_second, n_second;
    logic out_free;

    assign out_free = !r_valid || !i_stall;

    always_comb begin
        n_valid  = r_valid;
        n_pend   = r_pend;
        n_res    = r_res;
        n_second = r_second;
        o_pop    = 1'b0;
        if (out_free) begin
            if (r_pend) begin
                n_valid = 1'b1;
                n_res   = r_second;
                n_pend  = 1'b0;
            end else if (i_head.valid) begin
                n_valid  = 1'b1;
                n_res    = i_head.cmd.first;
                n_pend   = i_head.cmd.two;
                n_second = i_head.cmd.second;
                o_pop    = 1'b1;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_second <= n_second;
    end

    assign o_valid = r_valid;
    assign o_data  = r_res;

    `CLAS_ASSERT_IMPLY(a_pend_shown, r_pend, r_valid)

endmodule

[src/command_line_argument_splitter_core.sv]
// result path: an accepted transaction enters the result queue, then its
//   first result goes to the output register; throughput: one transaction
//   per cycle; one with two results holds the output for both, absorbed by
//   the 4-entry result queue until it fills, then the input stalls
// reset (synchronous, active low) returns the splitter to line start and empties
//   the queue and output register
module command_line_argument_splitter_core import clas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_res o_data
);

    // front to queue
    logic   push;
    t_cmd   cmd;
    logic   full;
    // queue to back
    t_qhead head;
    logic   pop;

    // front end classifies each code unit and updates phase, quote count and
    // the held backslash run; it stalls only when the queue is full
    clas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .i_full  (full),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    // queue decouples input acceptance from output stalls
    clas_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    // back end delivers each result of a queued entry, one at a time, on the output channel
    clas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

endmodule

[tb/tb_top.sv]
// self-checking testbench for command_line_argument_splitter_core
// depends on clas_pkg and the splitter rtl; predicts results with its own split model
`timescale 1ns / 100ps

module tb_top;
    import clas_pkg::*;

    localparam int RandomUnits = 1600;
    localparam int CycleLimit  = 400000;
    localparam int DrainCycles = 16;

    // receiver stall patterns, picked at random by the monitor
    typedef enum logic [1:0] {
        STALL_NONE     = 2'd0,
        STALL_LIGHT    = 2'd1,
        STALL_HEAVY    = 2'd2,
        STALL_PERIODIC = 2'd3
    } t_stall_mode;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data  = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_res o_data;

    command_line_argument_splitter_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // command line units waiting to be driven, in order
    t_in  line_units[$];
    // appends and markers the splitter owes us, oldest first
    t_res predicted_results[$];

    // split state of the predictor
    t_phase     ph      = PH_START;
    logic [1:0] qcnt    = 2'd0;
    logic [7:0] bs_run  = 8'd0;
    logic       in_qrun = 1'b0;
    logic       ov_pend = 1'b0;

    int lines_done   = 0;
    int txn_cnt      = 0;
    int results_seen = 0;
    int mismatch_cnt = 0;
    int long_runs    = 0;
    int long_units   = 0;
    int cycle_cnt    = 0;

    // sender burst and gap bookkeeping
    int burst_left = 8;
    int gap_left   = 0;

    // receiver stall pattern
    int          stall_tick = 0;
    t_stall_mode stall_mode = STALL_NONE;
    t_res        head_res;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic bit is_blank_unit(logic [15:0] u);
        return u == ChSpace || u == ChTab;
    endfunction

    // one append record; the unit reads as zero when nothing is appended
    function automatic void predict_append(logic [15:0] u, logic [7:0] rep,
                                           logic ae, logic le, logic ov);
        t_res r;
        r.out_unit   = (rep != 8'd0) ? u : 16'h0000;
        r.repeat_res = rep;
        r.arg_end    = ae;
        r.line_end   = le;
        r.overflow   = ov;
        predicted_results.push_back(r);
    endfunction

    function automatic void clear_split_state();
        ph      = PH_START;
        qcnt    = 2'd0;
        bs_run  = 8'd0;
        in_qrun = 1'b0;
        ov_pend = 1'b0;
    endfunction

    // a unit inside an argument: backslash runs, quote runs, blanks
    function automatic void split_arg_unit(logic [15:0] u);
        logic       ov;
        logic [7:0] half;
        int         n;
        ov = ov_pend;
        n  = 0;
        if (in_qrun) begin
            if (u == ChQuote) begin
                // every third quote in a run comes out literally
                qcnt = qcnt + 2'd1;
                if (qcnt == QuoteWrap) begin
                    predict_append(ChQuote, 8'd1, 1'b0, 1'b0, 1'b0);
                    qcnt = 2'd0;
                end
                return;
            end
            if (qcnt == 2'd2)
                qcnt = 2'd0;
            in_qrun = 1'b0;
        end
        if (is_blank_unit(u) && qcnt == 2'd0) begin
            predict_append(ChBslash, bs_run, 1'b1, 1'b0, ov);
            bs_run  = 8'd0;
            ov_pend = 1'b0;
            ph      = PH_GAP;
        end else if (u == ChBslash) begin
            if (bs_run < MaxBackslashRun)
                bs_run = bs_run + 8'd1;
            else
                ov_pend = 1'b1;
        end else if (u == ChQuote) begin
            half = bs_run >> 1;
            if (half != 8'd0) begin
                predict_append(ChBslash, half, 1'b0, 1'b0, ov);
                n++;
            end
            if (!bs_run[0])
                qcnt = qcnt + 2'd1;
            else
                predict_append(ChQuote, 8'd1, 1'b0, 1'b0, (n == 0) ? ov : 1'b0);
            bs_run  = 8'd0;
            ov_pend = 1'b0;
            in_qrun = 1'b1;
        end else begin
            if (bs_run != 8'd0) begin
                predict_append(ChBslash, bs_run, 1'b0, 1'b0, ov);
                n++;
            end
            predict_append(u, 8'd1, 1'b0, 1'b0, (n == 0) ? ov : 1'b0);
            bs_run  = 8'd0;
            ov_pend = 1'b0;
        end
    endfunction

    // one accepted input transaction
    function automatic void split_unit(t_in item);
        logic [15:0] u;
        u = item.unit;
        if (item.terminator) begin
            case (ph)
                PH_START, PH_QPATH, PH_UPATH: begin
                    predict_append(16'h0000, 8'd0, 1'b1, 1'b1, 1'b0);
                end
                PH_ARG: begin
                    predict_append(ChBslash, bs_run, 1'b1, 1'b1, ov_pend);
                end
                default: begin
                    predict_append(16'h0000, 8'd0, 1'b0, 1'b1, 1'b0);
                end
            endcase
            clear_split_state();
            lines_done++;
            return;
        end
        case (ph)
            PH_START: begin
                if (u == ChQuote) begin
                    ph = PH_QPATH;
                end else if (is_blank_unit(u)) begin
                    predict_append(16'h0000, 8'd0, 1'b1, 1'b0, 1'b0);
                    ph = PH_GAP;
                end else begin
                    predict_append(u, 8'd1, 1'b0, 1'b0, 1'b0);
                    ph = PH_UPATH;
                end
            end
            PH_QPATH: begin
                if (u == ChQuote) begin
                    predict_append(16'h0000, 8'd0, 1'b1, 1'b0, 1'b0);
                    ph = PH_GAP;
                end else begin
                    predict_append(u, 8'd1, 1'b0, 1'b0, 1'b0);
                end
            end
            PH_UPATH: begin
                if (is_blank_unit(u)) begin
                    predict_append(16'h0000, 8'd0, 1'b1, 1'b0, 1'b0);
                    ph = PH_GAP;
                end else begin
                    predict_append(u, 8'd1, 1'b0, 1'b0, 1'b0);
                end
            end
            PH_ARG: begin
                split_arg_unit(u);
            end
            default: begin
                // gap: the first non-blank opens a fresh argument
                if (!is_blank_unit(u)) begin
                    clear_split_state();
                    ph = PH_ARG;
                    split_arg_unit(u);
                end else begin
                    ph = PH_GAP;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void add_unit(logic [15:0] u);
        line_units.push_back(t_in'{unit: u, terminator: 1'b0});
    endfunction

    // the unit field is ignored on a terminator, so it carries noise
    function automatic void add_term();
        line_units.push_back(t_in'{unit: 16'($urandom), terminator: 1'b1});
    endfunction

    function automatic void add_text(string s);
        for (int k = 0; k < s.len(); k++)
            add_unit({8'h00, s[k]});
    endfunction

    function automatic logic [15:0] pick_blank();
        return $urandom_range(0, 1) ? ChSpace : ChTab;
    endfunction

    // weighted toward the units that steer the splitter
    function automatic logic [15:0] pick_unit();
        case ($urandom_range(0, 9))
            0, 1:    return ChBslash;
            2, 3:    return ChQuote;
            4, 5:    return pick_blank();
            6, 7:    return 16'h0061 + 16'($urandom_range(0, 25));
            default: return 16'($urandom);
        endcase
    endfunction

    // one command line ending in the terminator: empty, noise, or a program path,
    // arguments of backslash runs, quote runs and plain units, maybe trailing blanks
    function automatic void build_line(bit with_long_run);
        int kind;
        int n_args;
        int run_len;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            add_term();
            return;
        end
        if (kind < 3) begin
            // noise line
            repeat ($urandom_range(1, 30)) add_unit(pick_unit());
            add_term();
            return;
        end
        case ($urandom_range(0, 3))
            0: begin
                add_unit(pick_blank());
            end
            1: begin
                add_unit(ChQuote);
                repeat ($urandom_range(0, 6)) add_unit(pick_unit());
                if ($urandom_range(0, 4) != 0)
                    add_unit(ChQuote);
            end
            default: begin
                repeat ($urandom_range(1, 6)) add_unit(pick_unit());
            end
        endcase
        n_args = $urandom_range(0, 5);
        if (with_long_run && n_args == 0)
            n_args = 1;
        for (int a = 0; a < n_args; a++) begin
            repeat ($urandom_range(1, 3)) add_unit(pick_blank());
            if (with_long_run && a == 0) begin
                // long run up to or past saturation, boundary lengths half of the time
                run_len = $urandom_range(0, 1) ? $urandom_range(254, 257)
                                               : $urandom_range(258, 300);
                repeat (run_len) add_unit(ChBslash);
                long_runs++;
                long_units += run_len;
            end
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 3))
                    0:       repeat ($urandom_range(1, 7)) add_unit(ChBslash);
                    1:       repeat ($urandom_range(1, 4)) add_unit(ChQuote);
                    default: add_unit(pick_unit());
                endcase
            end
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) add_unit(pick_blank());
        add_term();
    endfunction

    // ------------------------------------------------------------------
    // driver: bursts of transactions with random gaps, payload held while stalled
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                split_unit(i_data);
                txn_cnt++;
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (line_units.size() == 0) begin
                    i_valid <= 1'b0;
                end else begin
                    i_data  <= line_units.pop_front();
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        // long bursts with no gap at all now and then
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transaction, drives the receiver stall
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (predicted_results.size() == 0) begin
                    if (mismatch_cnt < 10)
                        $display("unexpected result: unit=%h rep=%0d arg_end=%b line_end=%b ov=%b",
                                 o_data.out_unit, o_data.repeat_res, o_data.arg_end,
                                 o_data.line_end, o_data.overflow);
                    mismatch_cnt++;
                end else begin
                    head_res = predicted_results.pop_front();
                    if (o_data.out_unit !== head_res.out_unit ||
                        o_data.repeat_res !== head_res.repeat_res ||
                        o_data.arg_end !== head_res.arg_end ||
                        o_data.line_end !== head_res.line_end ||
                        o_data.overflow !== head_res.overflow) begin
                        if (mismatch_cnt < 10) begin
                            $display("mismatch at result %0d", results_seen);
                            $display("  expected unit=%h rep=%0d arg_end=%b line_end=%b ov=%b",
                                     head_res.out_unit, head_res.repeat_res,
                                     head_res.arg_end, head_res.line_end, head_res.overflow);
                            $display("  actual   unit=%h rep=%0d arg_end=%b line_end=%b ov=%b",
                                     o_data.out_unit, o_data.repeat_res, o_data.arg_end,
                                     o_data.line_end, o_data.overflow);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 64 == 0)
                stall_mode = t_stall_mode'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:  i_stall <= 1'b0;
                STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
                default:     i_stall <= (stall_tick % 5 < 2);
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------

    initial begin
        int directed_n;
        int line_idx;

        // empty line: one empty closed argument
        add_term();
        // leading tab, extreme unit, even run before a quote, quote run of four,
        // backslash still held and quote still open at the terminator
        add_unit(ChTab);
        add_unit(16'hFFFF);
        add_text("\\\\\"\"\"\"\\");
        add_term();
        // quoted program path with a zero unit, then an open quote at the end
        add_text("\"");
        add_unit(16'h0000);
        add_text("\" \"x");
        add_term();
        // unquoted path, odd run makes the quote literal, trailing blanks
        add_text("p \\\\\\\"  ");
        add_term();
        directed_n = line_units.size();

        // random lines; a long backslash run in every twentieth with a program path
        line_idx = 0;
        while (line_units.size() < directed_n + RandomUnits) begin
            build_line(line_idx % 20 == 7);
            line_idx++;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every transaction to go in and every result to come out
        while (line_units.size() != 0 || i_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        mismatch_cnt += predicted_results.size();

        $display("split %0d command lines from %0d input transactions, %0d saturating runs (%0d units)",
                 lines_done, txn_cnt, long_runs, long_units);
        $display("%0d results compared, %0d mismatches", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[command_line_argument_splitter_core.f]
+incdir+src
src/clas_pkg.sv
src/clas_front.sv
src/clas_queue.sv
src/clas_back.sv
src/command_line_argument_splitter_core.sv
tb/tb_top.sv
